// ===== hw/rtl/square_matrix_multiply_unit_macros.svh =====
// Assertion macros shared by the matrix multiply RTL.
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define SMM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smm assertion failed");

// Next-cycle implication, checked on clk, off during reset.
`define SMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smm assertion failed");

`endif

// ===== hw/rtl/smm_pkg.sv =====
// Shared types and constants of the matrix multiply unit.
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;

  localparam int DIM     = 8;               // active matrix side, 1..8
  localparam int SIDE    = 8;               // storage side (lanes and rows)
  localparam int IDX_W   = 3;               // row/column index width
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SUM1_W  = PROD_W + 1;      // pairs
  localparam int SUM2_W  = PROD_W + 2;      // quads
  localparam int VALUE_W = PROD_W + 3;      // full dot product

  localparam logic [IDX_W:0]   DIM_LIM  = (IDX_W + 1)'(DIM);
  localparam logic [IDX_W-1:0] DIM_LAST = IDX_W'(DIM - 1);

  typedef enum logic [1:0] {
    MODE_WR_A    = 2'd0,
    MODE_WR_B    = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_t;

  // Controller -> datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [IDX_W-1:0] wr_row;
    logic [IDX_W-1:0] wr_col;
    logic             issue;
    logic [IDX_W-1:0] rd_i;
    logic [IDX_W-1:0] rd_j;
    logic             last;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic advance;     // pipeline moves this cycle
    logic pipe_empty;  // no element in flight or waiting at the output
  } sts_t;

  // Coordinates that travel with an element down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic             last;
  } coord_t;

endpackage
`default_nettype wire

// ===== hw/rtl/smm_ctrl.sv =====
// Controller: input handshake, write decode and product element sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "square_matrix_multiply_unit_macros.svh"
module smm_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [smm_pkg::IDX_W-1:0]    in_row,
  input  wire logic [smm_pkg::IDX_W-1:0]    in_col,
  input  wire smm_pkg::sts_t                sts,
  output smm_pkg::cmd_t                     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [smm_pkg::IDX_W-1:0]   i_r, i_nxt;
  logic [smm_pkg::IDX_W-1:0]   j_r, j_nxt;
  logic                        accept;
  logic                        in_range;
  logic                        last_pos;
  smm_pkg::mode_t              mode;

  assign mode     = smm_pkg::mode_t'(in_mode);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, in_row} < smm_pkg::DIM_LIM) &&
                    ({1'b0, in_col} < smm_pkg::DIM_LIM);
  assign last_pos = (i_r == smm_pkg::DIM_LAST) && (j_r == smm_pkg::DIM_LAST);

  always_comb begin
    cmd        = '0;
    cmd.wr_row = in_row;
    cmd.wr_col = in_col;
    cmd.rd_i   = i_r;
    cmd.rd_j   = j_r;
    cmd.last   = last_pos;
    cmd.issue  = (state_r == ST_RUN) && sts.advance;
    cmd.wr_a   = accept && in_range && (mode == smm_pkg::MODE_WR_A);
    cmd.wr_b   = accept && in_range && (mode == smm_pkg::MODE_WR_B);
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (mode == smm_pkg::MODE_COMPUTE)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.issue) begin
          if (last_pos) begin
            state_nxt = ST_DRAIN;
          end else if (j_r == smm_pkg::DIM_LAST) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // Writes only land with nothing in flight.
  `SMM_ASSERT_NOW(a_wr_when_empty, cmd.wr_a || cmd.wr_b, sts.pipe_empty)
  // Compute transaction starts the sweep at element (0,0).
  `SMM_ASSERT_NEXT(a_start_sweep, accept && (mode == smm_pkg::MODE_COMPUTE),
    (state_r == ST_RUN) && (i_r == '0) && (j_r == '0))
  // Issuing the final element ends the sweep.
  `SMM_ASSERT_NEXT(a_end_sweep, cmd.issue && last_pos, state_r == ST_DRAIN)

endmodule
`default_nettype wire

// ===== hw/rtl/smm_datapath.sv =====
// Datapath: lane memories for A and B, lane multipliers, adder tree, output register.
`timescale 1ns / 1ps
`default_nettype none
module smm_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire smm_pkg::cmd_t                        cmd,
  input  wire logic signed [smm_pkg::ELEM_W-1:0]    in_element,
  output smm_pkg::sts_t                             sts,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [smm_pkg::VALUE_W-1:0]        out_product_value,
  output logic [smm_pkg::IDX_W-1:0]                 out_row,
  output logic [smm_pkg::IDX_W-1:0]                 out_col,
  output logic                                      out_last
);

  logic advance;

  logic signed [smm_pkg::ELEM_W-1:0]  a_rd_r [smm_pkg::SIDE];
  logic signed [smm_pkg::ELEM_W-1:0]  b_rd_r [smm_pkg::SIDE];
  logic signed [smm_pkg::PROD_W-1:0]  prod_r [smm_pkg::SIDE];
  logic signed [smm_pkg::SUM1_W-1:0]  sum1_r [smm_pkg::SIDE/2];
  logic signed [smm_pkg::SUM2_W-1:0]  sum2_r [smm_pkg::SIDE/4];
  logic signed [smm_pkg::VALUE_W-1:0] value_r;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  smm_pkg::coord_t c1_r, c2_r, c3_r, c4_r, out_c_r;

  assign advance        = !out_valid_r || out_ready;
  assign sts.advance    = advance;
  assign sts.pipe_empty = !(v1_r || v2_r || v3_r || v4_r || out_valid_r);

  // Lane k holds column k of A (addressed by row) and row k of B
  // (addressed by column), so one address per side reads a full dot product.
  for (genvar k = 0; k < smm_pkg::SIDE; k++) begin : g_lane
    logic signed [smm_pkg::ELEM_W-1:0] a_mem [smm_pkg::SIDE];
    logic signed [smm_pkg::ELEM_W-1:0] b_mem [smm_pkg::SIDE];

    always_ff @(posedge clk) begin
      if (cmd.wr_a && (cmd.wr_col == smm_pkg::IDX_W'(k))) begin
        a_mem[cmd.wr_row] <= in_element;
      end
      if (cmd.wr_b && (cmd.wr_row == smm_pkg::IDX_W'(k))) begin
        b_mem[cmd.wr_col] <= in_element;
      end
      if (advance) begin
        a_rd_r[k] <= a_mem[cmd.rd_i];
        b_rd_r[k] <= b_mem[cmd.rd_j];
      end
    end

    if (k < smm_pkg::DIM) begin : g_act
      always_ff @(posedge clk) begin
        if (advance) begin
          prod_r[k] <= a_rd_r[k] * b_rd_r[k];
        end
      end
    end else begin : g_idle
      always_ff @(posedge clk) begin
        prod_r[k] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int p = 0; p < smm_pkg::SIDE/2; p++) begin
        sum1_r[p] <= smm_pkg::SUM1_W'(prod_r[2*p]) + smm_pkg::SUM1_W'(prod_r[2*p+1]);
      end
      for (int p = 0; p < smm_pkg::SIDE/4; p++) begin
        sum2_r[p] <= smm_pkg::SUM2_W'(sum1_r[2*p]) + smm_pkg::SUM2_W'(sum1_r[2*p+1]);
      end
      value_r <= smm_pkg::VALUE_W'(sum2_r[0]) + smm_pkg::VALUE_W'(sum2_r[1]);
      c1_r    <= '{i: cmd.rd_i, j: cmd.rd_j, last: cmd.last};
      c2_r    <= c1_r;
      c3_r    <= c2_r;
      c4_r    <= c3_r;
      out_c_r <= c4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = value_r;
  assign out_row           = out_c_r.i;
  assign out_col           = out_c_r.j;
  assign out_last          = out_c_r.last;

endmodule
`default_nettype wire

// ===== hw/rtl/square_matrix_multiply_unit.sv =====
// Top level of the integer square matrix multiply unit.
`timescale 1ns / 1ps
`default_nettype none
// Multiplies two 8x8 matrices of signed 16-bit elements into exact signed
// 35-bit results. Each input transaction either writes one element of A
// (mode 0) or B (mode 1) at (in_row, in_col), or starts a product (mode 2);
// writes with an index outside the matrix and mode 3 are dropped. A compute
// transaction emits all 64 product elements row by row, column fastest,
// with out_last on element (7,7). The sequencer issues one element per
// cycle while the output is not stalled: 8 lane multipliers feed a
// registered adder tree, and each element passes the read registers, the
// products, the pair sums, the quad sums and the output register. With
// the output always taken a compute holds in_ready low while the elements
// issue, until the last element has left the output register, and while
// the controller returns to idle. Output backpressure stalls the whole
// pipeline and the sequencer and keeps in_ready low for longer. Elements
// must be written before they are used; storage is not cleared at reset.
module square_matrix_multiply_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_mode,
  input  wire logic [smm_pkg::IDX_W-1:0]          in_row,
  input  wire logic [smm_pkg::IDX_W-1:0]          in_col,
  input  wire logic signed [smm_pkg::ELEM_W-1:0]  in_element,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [smm_pkg::VALUE_W-1:0]      out_product_value,
  output logic [smm_pkg::IDX_W-1:0]               out_row,
  output logic [smm_pkg::IDX_W-1:0]               out_col,
  output logic                                    out_last
);

  smm_pkg::cmd_t cmd;  // write strobes and sequencer coordinates
  smm_pkg::sts_t sts;  // pipeline advance and empty flags

  smm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_row   (in_row),
    .in_col   (in_col),
    .sts      (sts),
    .cmd      (cmd)
  );

  smm_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_element        (in_element),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_value (out_product_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
